// File: hw/rtl/srso_pkg.sv
`timescale 1ns / 1ps

package srso_pkg;

	localparam int CRD_W  = 24;   // coordinate width, signed q12.12
	localparam int RAD_W  = 23;   // radius width, unsigned q11.12
	localparam int DIF_W  = 25;   // coordinate difference
	localparam int OPN_W  = 26;   // multiplier operand, signed
	localparam int PROD_W = 52;   // multiplier product
	localparam int ACC_W  = 53;   // dot product / norm accumulators
	localparam int HALF_W = 25;   // half of a 50-bit magnitude
	localparam int WIDE_W = 102;  // (d.w)^2 - c*|d|^2 accumulator
	localparam int CNT_W  = 9;    // holds a slot count up to 256
	localparam int STEP_W = 4;

	localparam int SPH_STEPS = 14;
	localparam int DD_STEPS  = 3;

	typedef enum logic [1:0] {
		CMD_SPHERE = 2'd0,
		CMD_LIGHT  = 2'd1,
		CMD_QUERY  = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		OPN_ZERO,
		OPN_DX, OPN_DY, OPN_DZ,
		OPN_WX, OPN_WY, OPN_WZ,
		OPN_R,
		OPN_M1, OPN_M0,
		OPN_C1, OPN_C0,
		OPN_D1, OPN_D0
	} opnd_t;

	typedef enum logic [1:0] {
		DST_DW,
		DST_C,
		DST_DD,
		DST_WIDE
	} dest_t;

	typedef enum logic [1:0] {
		SH_0,
		SH_25,
		SH_26,
		SH_50
	} shift_t;

	typedef struct packed {
		opnd_t  opa;
		opnd_t  opb;
		dest_t  dest;
		shift_t sh;
		logic   sub;
		logic   clr;
	} mop_t;

	typedef struct packed {
		logic issue;
		mop_t op;
		logic load_d;
		logic load_w;
	} mac_ctl_t;

	typedef struct packed {
		logic dw_neg;
		logic c_pos;
		logic wide_ge;
	} mac_stat_t;

	typedef struct packed {
		logic [CRD_W-1:0] cx;
		logic [CRD_W-1:0] cy;
		logic [CRD_W-1:0] cz;
		logic [RAD_W-1:0] rad;
	} sphere_t;

	typedef struct packed {
		logic [CRD_W-1:0] px;
		logic [CRD_W-1:0] py;
		logic [CRD_W-1:0] pz;
	} light_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LREAD,
		ST_DIR,
		ST_DD,
		ST_SREAD,
		ST_WSET,
		ST_SPH,
		ST_DRAIN,
		ST_DECIDE
	} state_t;

	// per-sphere program: d.w, then c, then (d.w)^2 - c*dd in 25-bit halves
	function automatic mop_t sph_op(logic [STEP_W-1:0] step);
		mop_t op;
		unique case (step)
			4'd0:  op = '{OPN_DX, OPN_WX, DST_DW,   SH_0,  1'b0, 1'b1};
			4'd1:  op = '{OPN_DY, OPN_WY, DST_DW,   SH_0,  1'b0, 1'b0};
			4'd2:  op = '{OPN_DZ, OPN_WZ, DST_DW,   SH_0,  1'b0, 1'b0};
			4'd3:  op = '{OPN_WX, OPN_WX, DST_C,    SH_0,  1'b0, 1'b1};
			4'd4:  op = '{OPN_WY, OPN_WY, DST_C,    SH_0,  1'b0, 1'b0};
			4'd5:  op = '{OPN_WZ, OPN_WZ, DST_C,    SH_0,  1'b0, 1'b0};
			4'd6:  op = '{OPN_R,  OPN_R,  DST_C,    SH_0,  1'b1, 1'b0};
			4'd7:  op = '{OPN_M1, OPN_M1, DST_WIDE, SH_50, 1'b0, 1'b1};
			4'd8:  op = '{OPN_M1, OPN_M0, DST_WIDE, SH_26, 1'b0, 1'b0};
			4'd9:  op = '{OPN_M0, OPN_M0, DST_WIDE, SH_0,  1'b0, 1'b0};
			4'd10: op = '{OPN_C1, OPN_D1, DST_WIDE, SH_50, 1'b1, 1'b0};
			4'd11: op = '{OPN_C1, OPN_D0, DST_WIDE, SH_25, 1'b1, 1'b0};
			4'd12: op = '{OPN_C0, OPN_D1, DST_WIDE, SH_25, 1'b1, 1'b0};
			4'd13: op = '{OPN_C0, OPN_D0, DST_WIDE, SH_0,  1'b1, 1'b0};
			default: op = '{OPN_ZERO, OPN_ZERO, DST_WIDE, SH_0, 1'b0, 1'b0};
		endcase
		return op;
	endfunction

	// per-query program: |d|^2
	function automatic mop_t dd_op(logic [STEP_W-1:0] step);
		mop_t op;
		unique case (step)
			4'd0:  op = '{OPN_DX, OPN_DX, DST_DD, SH_0, 1'b0, 1'b1};
			4'd1:  op = '{OPN_DY, OPN_DY, DST_DD, SH_0, 1'b0, 1'b0};
			4'd2:  op = '{OPN_DZ, OPN_DZ, DST_DD, SH_0, 1'b0, 1'b0};
			default: op = '{OPN_ZERO, OPN_ZERO, DST_DD, SH_0, 1'b0, 1'b0};
		endcase
		return op;
	endfunction

endpackage

// File: hw/rtl/srso_tables.sv
`timescale 1ns / 1ps

module srso_tables #(
	parameter int  SPHERE_SLOTS = 16,
	parameter int  LIGHT_SLOTS  = 16,
	localparam int SW = (SPHERE_SLOTS > 1) ? $clog2(SPHERE_SLOTS) : 1,
	localparam int LW = (LIGHT_SLOTS > 1) ? $clog2(LIGHT_SLOTS) : 1
) (
	input  logic                   clk,
	input  logic                   sph_we,
	input  logic [SW-1:0]          sph_waddr,
	input  srso_pkg::sphere_t      sph_wdata,
	input  logic [SW-1:0]          sph_raddr,
	output srso_pkg::sphere_t      sph_rd,
	input  logic                   lgt_we,
	input  logic [LW-1:0]          lgt_waddr,
	input  srso_pkg::light_t       lgt_wdata,
	input  logic [LW-1:0]          lgt_raddr,
	output srso_pkg::light_t       lgt_rd
);

	srso_pkg::sphere_t sph_mem [SPHERE_SLOTS];
	srso_pkg::light_t  lgt_mem [LIGHT_SLOTS];
	srso_pkg::sphere_t sph_rd_q;
	srso_pkg::light_t  lgt_rd_q;

	always_ff @(posedge clk) begin
		if (sph_we) begin
			sph_mem[sph_waddr] <= sph_wdata;
		end
		sph_rd_q <= sph_mem[sph_raddr];
	end

	always_ff @(posedge clk) begin
		if (lgt_we) begin
			lgt_mem[lgt_waddr] <= lgt_wdata;
		end
		lgt_rd_q <= lgt_mem[lgt_raddr];
	end

	assign sph_rd = sph_rd_q;
	assign lgt_rd = lgt_rd_q;

endmodule

// File: hw/rtl/srso_mac.sv
`timescale 1ns / 1ps

module srso_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load_p,
	input  logic [srso_pkg::CRD_W-1:0]    pos_x,
	input  logic [srso_pkg::CRD_W-1:0]    pos_y,
	input  logic [srso_pkg::CRD_W-1:0]    pos_z,
	input  srso_pkg::light_t              lgt,
	input  srso_pkg::sphere_t             sph,
	input  srso_pkg::mac_ctl_t            ctl,
	output srso_pkg::mac_stat_t           stat
);

	localparam int CW = srso_pkg::CRD_W;
	localparam int DW = srso_pkg::DIF_W;
	localparam int OW = srso_pkg::OPN_W;
	localparam int PW = srso_pkg::PROD_W;
	localparam int AW = srso_pkg::ACC_W;
	localparam int HW = srso_pkg::HALF_W;
	localparam int XW = srso_pkg::WIDE_W;

	logic [CW-1:0] p_x_q, p_y_q, p_z_q;
	logic [DW-1:0] d_x_q, d_y_q, d_z_q;
	logic [DW-1:0] w_x_q, w_y_q, w_z_q;
	logic [srso_pkg::RAD_W-1:0] r_q;

	logic [AW-1:0] acc_dw_q, acc_c_q, acc_dd_q;
	logic [XW-1:0] acc_wide_q;

	logic signed [PW-1:0] p_s1;
	srso_pkg::mop_t       op_s1;
	logic                 vld_s1;

	logic [AW-1:0]        mag;
	logic signed [OW-1:0] opa, opb;
	logic signed [PW-1:0] prod;
	logic [XW-1:0]        ext, addend, base, sum;

	// magnitude of a negative d.w; only meaningful when d.w < 0
	assign mag = -acc_dw_q;

	function automatic logic signed [OW-1:0] pick(srso_pkg::opnd_t s);
		logic signed [OW-1:0] v;
		unique case (s)
			srso_pkg::OPN_DX: v = {d_x_q[DW-1], d_x_q};
			srso_pkg::OPN_DY: v = {d_y_q[DW-1], d_y_q};
			srso_pkg::OPN_DZ: v = {d_z_q[DW-1], d_z_q};
			srso_pkg::OPN_WX: v = {w_x_q[DW-1], w_x_q};
			srso_pkg::OPN_WY: v = {w_y_q[DW-1], w_y_q};
			srso_pkg::OPN_WZ: v = {w_z_q[DW-1], w_z_q};
			srso_pkg::OPN_R:  v = {{(OW-srso_pkg::RAD_W){1'b0}}, r_q};
			srso_pkg::OPN_M1: v = {1'b0, mag[2*HW-1:HW]};
			srso_pkg::OPN_M0: v = {1'b0, mag[HW-1:0]};
			srso_pkg::OPN_C1: v = {1'b0, acc_c_q[2*HW-1:HW]};
			srso_pkg::OPN_C0: v = {1'b0, acc_c_q[HW-1:0]};
			srso_pkg::OPN_D1: v = {1'b0, acc_dd_q[2*HW-1:HW]};
			srso_pkg::OPN_D0: v = {1'b0, acc_dd_q[HW-1:0]};
			default:          v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		opa  = pick(ctl.op.opa);
		opb  = pick(ctl.op.opb);
		prod = opa * opb;
	end

	// accumulate stage: shift the registered product, +/- it into one accumulator
	always_comb begin
		ext = {{(XW-PW){p_s1[PW-1]}}, p_s1};
		unique case (op_s1.sh)
			srso_pkg::SH_0:  addend = ext;
			srso_pkg::SH_25: addend = ext << 25;
			srso_pkg::SH_26: addend = ext << 26;
			srso_pkg::SH_50: addend = ext << 50;
			default:         addend = ext;
		endcase
		if (op_s1.clr) begin
			base = '0;
		end else begin
			unique case (op_s1.dest)
				srso_pkg::DST_DW:   base = {{(XW-AW){acc_dw_q[AW-1]}}, acc_dw_q};
				srso_pkg::DST_C:    base = {{(XW-AW){acc_c_q[AW-1]}}, acc_c_q};
				srso_pkg::DST_DD:   base = {{(XW-AW){acc_dd_q[AW-1]}}, acc_dd_q};
				srso_pkg::DST_WIDE: base = acc_wide_q;
				default:            base = acc_wide_q;
			endcase
		end
		sum = op_s1.sub ? (base - addend) : (base + addend);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		p_s1  <= prod;
		op_s1 <= ctl.op;
		if (load_p) begin
			p_x_q <= pos_x;
			p_y_q <= pos_y;
			p_z_q <= pos_z;
		end
		if (ctl.load_d) begin
			d_x_q <= {lgt.px[CW-1], lgt.px} - {p_x_q[CW-1], p_x_q};
			d_y_q <= {lgt.py[CW-1], lgt.py} - {p_y_q[CW-1], p_y_q};
			d_z_q <= {lgt.pz[CW-1], lgt.pz} - {p_z_q[CW-1], p_z_q};
		end
		if (ctl.load_w) begin
			w_x_q <= {p_x_q[CW-1], p_x_q} - {sph.cx[CW-1], sph.cx};
			w_y_q <= {p_y_q[CW-1], p_y_q} - {sph.cy[CW-1], sph.cy};
			w_z_q <= {p_z_q[CW-1], p_z_q} - {sph.cz[CW-1], sph.cz};
			r_q   <= sph.rad;
		end
		if (vld_s1) begin
			unique case (op_s1.dest)
				srso_pkg::DST_DW:   acc_dw_q   <= sum[AW-1:0];
				srso_pkg::DST_C:    acc_c_q    <= sum[AW-1:0];
				srso_pkg::DST_DD:   acc_dd_q   <= sum[AW-1:0];
				srso_pkg::DST_WIDE: acc_wide_q <= sum;
				default:            acc_wide_q <= sum;
			endcase
		end
	end

	assign stat.dw_neg  = acc_dw_q[AW-1];
	assign stat.c_pos   = !acc_c_q[AW-1] && (acc_c_q != '0);
	assign stat.wide_ge = !acc_wide_q[XW-1];

endmodule

// File: hw/rtl/srso_seq.sv
`timescale 1ns / 1ps

module srso_seq #(
	parameter int  SPHERE_SLOTS = 16,
	localparam int SW = (SPHERE_SLOTS > 1) ? $clog2(SPHERE_SLOTS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          query,
	input  logic                          light_ok,
	input  logic [srso_pkg::CNT_W-1:0]    n_lim,
	input  srso_pkg::mac_stat_t           stat,
	output srso_pkg::mac_ctl_t            ctl,
	output logic [SW-1:0]                 sph_addr,
	output logic                          busy,
	output logic                          done,
	output logic                          occluded
);

	localparam int NW = srso_pkg::CNT_W;
	localparam int TW = srso_pkg::STEP_W;

	srso_pkg::state_t state_q, state_nx;
	logic [TW-1:0] step_q;
	logic [NW-1:0] sph_q, n_q, sph_nx;
	logic          light_ok_q, done_q, occ_q;

	logic fin, hit, inc, step_adv, blk, last;

	assign sph_nx = sph_q + NW'(1);
	assign blk    = stat.dw_neg && stat.c_pos && stat.wide_ge;
	assign last   = (sph_nx >= n_q);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			srso_pkg::ST_IDLE: begin
				if (query) state_nx = srso_pkg::ST_LREAD;
			end
			srso_pkg::ST_LREAD: state_nx = srso_pkg::ST_DIR;
			srso_pkg::ST_DIR: begin
				if (!light_ok_q || (n_q == '0)) state_nx = srso_pkg::ST_IDLE;
				else state_nx = srso_pkg::ST_DD;
			end
			srso_pkg::ST_DD: begin
				if (step_q == TW'(srso_pkg::DD_STEPS - 1)) state_nx = srso_pkg::ST_SREAD;
			end
			srso_pkg::ST_SREAD: state_nx = srso_pkg::ST_WSET;
			srso_pkg::ST_WSET:  state_nx = srso_pkg::ST_SPH;
			srso_pkg::ST_SPH: begin
				if (step_q == TW'(srso_pkg::SPH_STEPS - 1)) state_nx = srso_pkg::ST_DRAIN;
			end
			srso_pkg::ST_DRAIN: state_nx = srso_pkg::ST_DECIDE;
			srso_pkg::ST_DECIDE: begin
				if (blk || last) state_nx = srso_pkg::ST_IDLE;
				else state_nx = srso_pkg::ST_SREAD;
			end
			default: state_nx = srso_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl      = '0;
		fin      = 1'b0;
		hit      = 1'b0;
		inc      = 1'b0;
		step_adv = 1'b0;
		unique case (state_q)
			srso_pkg::ST_IDLE, srso_pkg::ST_LREAD, srso_pkg::ST_SREAD,
			srso_pkg::ST_DRAIN: begin
			end
			srso_pkg::ST_DIR: begin
				ctl.load_d = 1'b1;
				fin        = !light_ok_q || (n_q == '0);
			end
			srso_pkg::ST_DD: begin
				ctl.issue = 1'b1;
				ctl.op    = srso_pkg::dd_op(step_q);
				step_adv  = (step_q != TW'(srso_pkg::DD_STEPS - 1));
			end
			srso_pkg::ST_WSET: ctl.load_w = 1'b1;
			srso_pkg::ST_SPH: begin
				ctl.issue = 1'b1;
				ctl.op    = srso_pkg::sph_op(step_q);
				step_adv  = (step_q != TW'(srso_pkg::SPH_STEPS - 1));
			end
			srso_pkg::ST_DECIDE: begin
				fin = blk || last;
				hit = blk;
				inc = !(blk || last);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= srso_pkg::ST_IDLE;
			step_q     <= '0;
			sph_q      <= '0;
			n_q        <= '0;
			light_ok_q <= 1'b0;
			done_q     <= 1'b0;
			occ_q      <= 1'b0;
		end else begin
			state_q <= state_nx;
			step_q  <= step_adv ? (step_q + TW'(1)) : '0;
			done_q  <= fin;
			occ_q   <= hit;
			if ((state_q == srso_pkg::ST_IDLE) && query) begin
				sph_q      <= '0;
				n_q        <= n_lim;
				light_ok_q <= light_ok;
			end else if (inc) begin
				sph_q <= sph_nx;
			end
		end
	end

	assign sph_addr = sph_q[SW-1:0];
	assign busy     = (state_q != srso_pkg::ST_IDLE);
	assign done     = done_q;
	assign occluded = occ_q;

endmodule

// File: hw/rtl/shadow_ray_sphere_occlusion_top.sv
`timescale 1ns / 1ps

// channel   direction  handshake                      payload
// command   in         start, busy (start && !busy)   cmd, index, pos_x, pos_y, pos_z, radius
// result    out        done (one-cycle strobe)        occluded
// config    in         apb: psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// a sphere or light load is written at the accepting edge and busy stays low
// a query walks the enabled spheres in order up to its done strobe
//   (the walk stops at the first blocking sphere); one 26x26 multiplier does all
//   14 products per sphere plus 3 per query for |d|^2, one per cycle
// with no sphere to test (sphere_count 0 or light index past the table) it ends at ST_DIR
// busy is high from the cycle after a query is taken and drops with its done strobe
// arst_n clears the fsm and sphere_count; table contents are not cleared
// the receiver cannot stall: occluded is valid only while done is high

module shadow_ray_sphere_occlusion_top #(
	parameter int SPHERE_SLOTS = 16,
	parameter int LIGHT_SLOTS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// command channel
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          cmd,
	input  logic [3:0]          index,
	input  logic signed [23:0]  pos_x,
	input  logic signed [23:0]  pos_y,
	input  logic signed [23:0]  pos_z,
	input  logic [22:0]         radius,
	// result channel
	output logic                done,
	output logic                occluded,
	// register port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int SW = (SPHERE_SLOTS > 1) ? $clog2(SPHERE_SLOTS) : 1;
	localparam int LW = (LIGHT_SLOTS > 1) ? $clog2(LIGHT_SLOTS) : 1;
	localparam int NW = srso_pkg::CNT_W;

	// sphere_count register, at byte address 0
	logic [4:0]    cnt_q;
	logic          reg_sel, reg_wr;

	logic          accept, is_query;
	logic [NW-1:0] idx_ext, cnt_ext, n_lim;
	logic          sph_in_range, lgt_in_range;
	logic [LW-1:0] lgt_addr_q;
	logic [SW-1:0] sph_addr;

	srso_pkg::sphere_t  sph_wdata, sph_rd;
	srso_pkg::light_t   lgt_wdata, lgt_rd;
	srso_pkg::mac_ctl_t ctl;
	srso_pkg::mac_stat_t stat;

	// apb: register index is the word address, low bits ignored
	assign reg_sel = !paddr[2];
	assign reg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {27'd0, cnt_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (reg_wr && reg_sel) begin
			cnt_q <= pwdata[4:0];
		end
	end

	// command decode
	assign accept       = start && !busy;
	assign is_query     = accept && (cmd == srso_pkg::CMD_QUERY);
	assign idx_ext      = NW'(index);
	assign sph_in_range = (idx_ext < NW'(SPHERE_SLOTS));
	assign lgt_in_range = (idx_ext < NW'(LIGHT_SLOTS));

	// spheres tested: sphere_count saturated at the table depth
	assign cnt_ext = NW'(cnt_q);
	assign n_lim   = (cnt_ext > NW'(SPHERE_SLOTS)) ? NW'(SPHERE_SLOTS) : cnt_ext;

	assign sph_wdata = '{cx: pos_x, cy: pos_y, cz: pos_z, rad: radius};
	assign lgt_wdata = '{px: pos_x, py: pos_y, pz: pos_z};

	// light read address held for the whole query
	always_ff @(posedge clk) begin
		if (is_query) begin
			lgt_addr_q <= idx_ext[LW-1:0];
		end
	end

	srso_tables #(
		.SPHERE_SLOTS (SPHERE_SLOTS),
		.LIGHT_SLOTS  (LIGHT_SLOTS)
	) u_tables (
		.clk       (clk),
		.sph_we    (accept && (cmd == srso_pkg::CMD_SPHERE) && sph_in_range),
		.sph_waddr (idx_ext[SW-1:0]),
		.sph_wdata (sph_wdata),
		.sph_raddr (sph_addr),
		.sph_rd    (sph_rd),
		.lgt_we    (accept && (cmd == srso_pkg::CMD_LIGHT) && lgt_in_range),
		.lgt_waddr (idx_ext[LW-1:0]),
		.lgt_wdata (lgt_wdata),
		.lgt_raddr (lgt_addr_q),
		.lgt_rd    (lgt_rd)
	);

	// shared multiplier, shift-add and accumulators
	srso_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.load_p (is_query),
		.pos_x  (pos_x),
		.pos_y  (pos_y),
		.pos_z  (pos_z),
		.lgt    (lgt_rd),
		.sph    (sph_rd),
		.ctl    (ctl),
		.stat   (stat)
	);

	// query sequencer: walks spheres, stops on the first blocker
	srso_seq #(
		.SPHERE_SLOTS (SPHERE_SLOTS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.query    (is_query),
		.light_ok (lgt_in_range),
		.n_lim    (n_lim),
		.stat     (stat),
		.ctl      (ctl),
		.sph_addr (sph_addr),
		.busy     (busy),
		.done     (done),
		.occluded (occluded)
	);

endmodule

// File: bench/srso_checker.sv
`timescale 1ns / 1ps

module srso_checker #(
	parameter int         SPHERE_SLOTS = 16,
	parameter int         LIGHT_SLOTS  = 16,
	parameter logic [2:0] COUNT_ADDR   = 3'd0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  logic [1:0]             cmd,
	input  logic [3:0]             index,
	input  logic signed [srso_pkg::CRD_W-1:0] pos_x,
	input  logic signed [srso_pkg::CRD_W-1:0] pos_y,
	input  logic signed [srso_pkg::CRD_W-1:0] pos_z,
	input  logic [srso_pkg::RAD_W-1:0]       radius,
	input  logic                   done,
	input  logic                   occluded,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic                   pready,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	input  logic                   leftover_check,
	output int                     fail_count,
	output int                     pending,
	output int                     query_count,
	output int                     hit_count
);

	logic signed [srso_pkg::CRD_W-1:0] sph_cx [SPHERE_SLOTS];
	logic signed [srso_pkg::CRD_W-1:0] sph_cy [SPHERE_SLOTS];
	logic signed [srso_pkg::CRD_W-1:0] sph_cz [SPHERE_SLOTS];
	logic [srso_pkg::RAD_W-1:0]        sph_rad [SPHERE_SLOTS];
	logic signed [srso_pkg::CRD_W-1:0] lit_x [LIGHT_SLOTS];
	logic signed [srso_pkg::CRD_W-1:0] lit_y [LIGHT_SLOTS];
	logic signed [srso_pkg::CRD_W-1:0] lit_z [LIGHT_SLOTS];
	logic [4:0]              tested_spheres;
	bit                      expected_occ [$];
	bit                      leftover_done;

	initial begin
		fail_count    = 0;
		pending       = 0;
		query_count   = 0;
		hit_count     = 0;
		leftover_done = 1'b0;
	end

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= 50)
			$display("%0t ns  mismatch: %s", $time, what);
	endtask

	// exact test: d.w < 0, c > 0 and (d.w)^2 >= c*|d|^2
	function automatic bit sphere_blocks(int s, longint dx, longint dy, longint dz,
			longint px, longint py, longint pz);
		longint wx, wy, wz, r, dw, c, dd;
		logic [127:0] lhs, rhs;
		wx = px - longint'(sph_cx[s]);
		wy = py - longint'(sph_cy[s]);
		wz = pz - longint'(sph_cz[s]);
		r  = longint'(sph_rad[s]);
		dw = dx * wx + dy * wy + dz * wz;
		c  = wx * wx + wy * wy + wz * wz - r * r;
		dd = dx * dx + dy * dy + dz * dz;
		if (dw >= 0 || c <= 0)
			return 1'b0;
		lhs = 128'(-dw) * 128'(-dw);
		rhs = 128'(c) * 128'(dd);
		return lhs >= rhs;
	endfunction

	function automatic bit ray_blocked(int li, longint px, longint py, longint pz);
		longint dx, dy, dz;
		int n;
		if (li >= LIGHT_SLOTS)
			return 1'b0;
		dx = longint'(lit_x[li]) - px;
		dy = longint'(lit_y[li]) - py;
		dz = longint'(lit_z[li]) - pz;
		n = (tested_spheres > SPHERE_SLOTS) ? SPHERE_SLOTS : int'(tested_spheres);
		for (int s = 0; s < n; s++)
			if (sphere_blocks(s, dx, dy, dz, px, py, pz))
				return 1'b1;
		return 1'b0;
	endfunction

	always @(posedge clk) begin
		bit want;
		if (!arst_n) begin
			tested_spheres = '0;
			expected_occ.delete();
		end else begin
			if (done) begin
				if (expected_occ.size() == 0) begin
					report_mismatch($sformatf("result with no query waiting, occluded=%b",
						occluded));
				end else begin
					want = expected_occ.pop_front();
					if (occluded !== want)
						report_mismatch($sformatf("occluded=%b, expected %b", occluded, want));
				end
			end
			if (psel && penable && pwrite && pready && paddr == COUNT_ADDR)
				tested_spheres = pwdata[4:0];
			if (start && !busy) begin
				case (cmd)
					srso_pkg::CMD_SPHERE: if (index < SPHERE_SLOTS) begin
						sph_cx[index]  = pos_x;
						sph_cy[index]  = pos_y;
						sph_cz[index]  = pos_z;
						sph_rad[index] = radius;
					end
					srso_pkg::CMD_LIGHT: if (index < LIGHT_SLOTS) begin
						lit_x[index] = pos_x;
						lit_y[index] = pos_y;
						lit_z[index] = pos_z;
					end
					srso_pkg::CMD_QUERY: begin
						want = ray_blocked(int'(index), longint'(pos_x), longint'(pos_y),
							longint'(pos_z));
						expected_occ.push_back(want);
						query_count++;
						if (want)
							hit_count++;
					end
					default: ;
				endcase
			end
			if (leftover_check && !leftover_done) begin
				leftover_done = 1'b1;
				if (expected_occ.size() != 0)
					report_mismatch($sformatf("%0d queries never answered",
						expected_occ.size()));
			end
			pending = expected_occ.size();
		end
	end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int               SLOTS             = 16;
	localparam logic [2:0]       SPHERE_COUNT_ADDR = 3'd0;
	localparam logic [1:0]       CMD_UNUSED        = 2'd3;
	// slowest query: all sixteen spheres walked
	localparam int               QUERY_CYCLES_MAX  = 5 + 18 * SLOTS;
	localparam int               ITEM_TARGET       = 1750;
	localparam int               ONE               = 4096;     // 1.0 in q12.12
	localparam int               SPAN              = 4 * ONE;
	localparam logic signed [23:0] CRD_MAX         = 24'sh7FFFFF;
	localparam logic signed [23:0] CRD_MIN         = 24'sh800000;
	localparam logic [22:0]      RAD_MAX           = 23'h7FFFFF;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         cmd;
	logic [3:0]         index;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic signed [23:0] pos_z;
	logic [22:0]        radius;
	logic               done;
	logic               occluded;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               leftover_check;

	int chk_fails;
	int chk_pending;
	int chk_queries;
	int chk_hits;

	// scene as last loaded, kept only to aim the shadow rays
	logic signed [23:0] scene_cx [SLOTS];
	logic signed [23:0] scene_cy [SLOTS];
	logic signed [23:0] scene_cz [SLOTS];
	logic [22:0]        scene_rad [SLOTS];
	int                 active_spheres;
	int                 items_sent;
	int                 burst_left;
	int                 settings_run;

	shadow_ray_sphere_occlusion_top #(
		.SPHERE_SLOTS(SLOTS),
		.LIGHT_SLOTS (SLOTS)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.index   (index),
		.pos_x   (pos_x),
		.pos_y   (pos_y),
		.pos_z   (pos_z),
		.radius  (radius),
		.done    (done),
		.occluded(occluded),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// prediction and comparison live in the checker; this module only drives
	srso_checker #(
		.SPHERE_SLOTS(SLOTS),
		.LIGHT_SLOTS (SLOTS),
		.COUNT_ADDR  (SPHERE_COUNT_ADDR)
	) chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.index         (index),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.radius        (radius),
		.done          (done),
		.occluded      (occluded),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.leftover_check(leftover_check),
		.fail_count    (chk_fails),
		.pending       (chk_pending),
		.query_count   (chk_queries),
		.hit_count     (chk_hits)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// gap after an item: mostly none or short, now and then long,
	// with occasional bursts of back-to-back items
	function automatic int pick_gap();
		int roll;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 4)
			burst_left = $urandom_range(10, 40);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// random coordinate within +-2^(bits-1)
	function automatic logic signed [23:0] near_coord(int bits);
		logic signed [23:0] v;
		v = 24'($urandom());
		return v >>> (24 - bits);
	endfunction

	function automatic bit fits24(longint v);
		return v >= -64'sd8388608 && v <= 64'sd8388607;
	endfunction

	// called right after a falling edge; returns right after a falling edge
	task automatic send_item(input logic [1:0] c, input logic [3:0] i,
			input logic signed [23:0] x, input logic signed [23:0] y,
			input logic signed [23:0] z, input logic [22:0] r);
		int n_gap;
		start  <= 1'b1;
		cmd    <= c;
		index  <= i;
		pos_x  <= x;
		pos_y  <= y;
		pos_z  <= z;
		radius <= r;
		// busy only moves on a rising edge, so its value here holds for the next edge
		while (busy)
			@(negedge clk);
		@(negedge clk);
		if (c == srso_pkg::CMD_SPHERE) begin
			scene_cx[i]  = x;
			scene_cy[i]  = y;
			scene_cz[i]  = z;
			scene_rad[i] = r;
		end
		if (c != CMD_UNUSED)
			items_sent++;
		n_gap = pick_gap();
		if (n_gap != 0) begin
			start <= 1'b0;
			// half the time the gap starts once the query has finished
			if (c == srso_pkg::CMD_QUERY && $urandom_range(0, 1) == 1)
				while (busy)
					@(negedge clk);
			repeat (n_gap)
				@(negedge clk);
		end
	endtask

	// wait for every query to be answered; loads finish at their accepting edge
	task automatic settle();
		start <= 1'b0;
		while (chk_pending != 0 || busy)
			@(negedge clk);
		repeat (4)
			@(negedge clk);
	endtask

	task automatic set_sphere_count(input logic [4:0] v);
		logic [26:0] junk;
		settle();
		junk = 27'($urandom());
		// setup cycle, upper bits carry junk the register must drop
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= SPHERE_COUNT_ADDR;
		pwdata  <= {junk, v};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		active_spheres = (v > SLOTS) ? SLOTS : int'(v);
		settings_run++;
	endtask

	// load a light so that the ray from a point to it crosses sphere s,
	// then query from that point; jitter turns some of them into misses
	task automatic shadow_pair();
		int s, li, m, axis;
		longint vx, vy, vz, t, r, px, py, pz, lx, ly, lz;
		s  = (active_spheres > 0) ? $urandom_range(0, active_spheres - 1) :
			$urandom_range(0, SLOTS - 1);
		li = $urandom_range(0, SLOTS - 1);
		if ($urandom_range(0, 3) == 0)
			send_item(srso_pkg::CMD_SPHERE, 4'(s), near_coord(22), near_coord(22),
				near_coord(22), 23'($urandom_range(0, 1 << 18)));
		r  = longint'(scene_rad[s]);
		vx = r + $urandom_range(1, 1 << 19);
		if ($urandom_range(0, 1) == 1)
			vx = -vx;
		vy = longint'(near_coord(17));
		vz = longint'(near_coord(17));
		axis = $urandom_range(0, 2);
		if (axis == 1) begin
			t = vx; vx = vy; vy = t;
		end else if (axis == 2) begin
			t = vx; vx = vz; vz = t;
		end
		m  = $urandom_range(1, 4);
		px = longint'(scene_cx[s]) + vx;
		py = longint'(scene_cy[s]) + vy;
		pz = longint'(scene_cz[s]) + vz;
		lx = longint'(scene_cx[s]) - m * vx;
		ly = longint'(scene_cy[s]) - m * vy;
		lz = longint'(scene_cz[s]) - m * vz;
		if ($urandom_range(0, 2) == 0) begin
			lx = lx + longint'(near_coord(12));
			ly = ly + longint'(near_coord(12));
			lz = lz + longint'(near_coord(12));
		end
		if (fits24(px) && fits24(py) && fits24(pz) && fits24(lx) && fits24(ly) &&
				fits24(lz)) begin
			send_item(srso_pkg::CMD_LIGHT, 4'(li), 24'(lx), 24'(ly), 24'(lz),
				23'($urandom()));
			send_item(srso_pkg::CMD_QUERY, 4'(li), 24'(px), 24'(py), 24'(pz),
				23'($urandom()));
		end else begin
			// scene too close to the edge of the range for this aim: plain query
			send_item(srso_pkg::CMD_QUERY, 4'(li), near_coord(22), near_coord(22),
				near_coord(22), 23'($urandom()));
		end
	endtask

	task automatic random_item();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45) begin
			shadow_pair();
		end else if (roll < 60) begin
			send_item(srso_pkg::CMD_QUERY, 4'($urandom_range(0, SLOTS - 1)), near_coord(22),
				near_coord(22), near_coord(22), 23'($urandom()));
		end else if (roll < 72) begin
			send_item(srso_pkg::CMD_SPHERE, 4'($urandom_range(0, SLOTS - 1)), near_coord(22),
				near_coord(22), near_coord(22), 23'($urandom_range(0, 1 << 18)));
		end else if (roll < 82) begin
			send_item(srso_pkg::CMD_LIGHT, 4'($urandom_range(0, SLOTS - 1)), near_coord(22),
				near_coord(22), near_coord(22), 23'($urandom()));
		end else if (roll < 95) begin
			// full-width noise so every input bit toggles
			send_item(2'($urandom_range(0, 2)), 4'($urandom()), near_coord(24),
				near_coord(24), near_coord(24), 23'($urandom()));
		end else begin
			send_item(CMD_UNUSED, 4'($urandom()), near_coord(24), near_coord(24),
				near_coord(24), 23'($urandom()));
		end
	endtask

	// hard stop in case the block stops answering
	initial begin
		#(25_000_000);
		$display("timeout with %0d queries still waiting", chk_pending);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int count_list [7];
		int quota;
		logic [4:0] next_count;
		count_list     = '{0, 1, 2, 16, 17, 31, 15};
		arst_n         = 1'b0;
		start          = 1'b0;
		cmd            = srso_pkg::CMD_SPHERE;
		index          = '0;
		pos_x          = '0;
		pos_y          = '0;
		pos_z          = '0;
		radius         = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		leftover_check = 1'b0;
		active_spheres = 0;
		items_sent     = 0;
		burst_left     = 0;
		settings_run   = 0;
		repeat (3)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fill every entry first so no query ever reads an unwritten slot;
		// spheres are parked far out in one corner, lights in another
		set_sphere_count(5'd0);
		for (int i = 0; i < SLOTS; i++) begin
			send_item(srso_pkg::CMD_SPHERE, 4'(i), 24'(7000000 + 1000 * i), 24'sd7000000,
				24'sd7000000, 23'(ONE * i));
			send_item(srso_pkg::CMD_LIGHT, 4'(i), -24'sd7000000, 24'(ONE * i), 24'sd0,
				23'($urandom()));
		end

		// unit sphere at the origin; with no spheres enabled nothing can block
		send_item(srso_pkg::CMD_SPHERE, 4'd0, 24'sd0, 24'sd0, 24'sd0, 23'(ONE));
		send_item(srso_pkg::CMD_LIGHT, 4'd0, 24'(-SPAN), 24'sd0, 24'sd0, 23'd0);
		send_item(srso_pkg::CMD_QUERY, 4'd0, 24'(SPAN), 24'sd0, 24'sd0, 23'd0);

		set_sphere_count(5'd1);
		// straight through the centre
		send_item(srso_pkg::CMD_QUERY, 4'd0, 24'(SPAN), 24'sd0, 24'sd0, 23'd0);
		// ray exactly tangent to the sphere: equality counts as a hit
		send_item(srso_pkg::CMD_LIGHT, 4'd1, 24'(-SPAN), 24'(ONE), 24'sd0, 23'd0);
		send_item(srso_pkg::CMD_QUERY, 4'd1, 24'(SPAN), 24'(ONE), 24'sd0, 23'd0);
		// one lsb outside tangent
		send_item(srso_pkg::CMD_LIGHT, 4'd2, 24'(-SPAN), 24'(ONE + 1), 24'sd0, 23'd0);
		send_item(srso_pkg::CMD_QUERY, 4'd2, 24'(SPAN), 24'(ONE + 1), 24'sd0, 23'd0);
		// sphere behind the point, ray points away
		send_item(srso_pkg::CMD_LIGHT, 4'd3, 24'(2 * SPAN), 24'sd0, 24'sd0, 23'd0);
		send_item(srso_pkg::CMD_QUERY, 4'd3, 24'(SPAN), 24'sd0, 24'sd0, 23'd0);
		// zero-length ray, point sits on the light
		send_item(srso_pkg::CMD_LIGHT, 4'd4, 24'(SPAN), 24'(SPAN), 24'(SPAN), 23'd0);
		send_item(srso_pkg::CMD_QUERY, 4'd4, 24'(SPAN), 24'(SPAN), 24'(SPAN), 23'd0);
		// point inside the sphere, then exactly on its surface
		send_item(srso_pkg::CMD_QUERY, 4'd0, 24'sd100, 24'sd0, 24'sd0, 23'd0);
		send_item(srso_pkg::CMD_QUERY, 4'd0, 24'(ONE), 24'sd0, 24'sd0, 23'd0);
		// command code 3 must be dropped without a result
		send_item(CMD_UNUSED, 4'hF, CRD_MAX, CRD_MIN, CRD_MAX, RAD_MAX);
		// full-range corners and the largest radius: widest intermediates
		send_item(srso_pkg::CMD_SPHERE, 4'd0, CRD_MIN, CRD_MIN, CRD_MIN, RAD_MAX);
		send_item(srso_pkg::CMD_LIGHT, 4'd15, CRD_MIN, CRD_MIN, CRD_MIN, RAD_MAX);
		send_item(srso_pkg::CMD_QUERY, 4'd15, CRD_MAX, CRD_MAX, CRD_MAX, RAD_MAX);
		send_item(srso_pkg::CMD_QUERY, 4'd15, CRD_MAX, CRD_MIN, CRD_MAX, 23'd0);

		// count above the table size saturates: only the last slot blocks
		set_sphere_count(5'd31);
		send_item(srso_pkg::CMD_SPHERE, 4'd0, 24'sd7000000, 24'sd7000000, 24'sd7000000,
			23'd1);
		send_item(srso_pkg::CMD_SPHERE, 4'd15, 24'sd0, 24'sd0, 24'sd0, 23'(ONE));
		send_item(srso_pkg::CMD_QUERY, 4'd0, 24'(SPAN), 24'sd0, 24'sd0, 23'd0);

		// random phases, each under its own sphere_count; extremes come first
		while (items_sent < ITEM_TARGET) begin
			if (settings_run < 3 + 7)
				next_count = 5'(count_list[settings_run - 3]);
			else if ($urandom_range(0, 1) == 1)
				next_count = 5'($urandom_range(8, 31));
			else
				next_count = 5'($urandom_range(0, 31));
			set_sphere_count(next_count);
			quota = items_sent + $urandom_range(60, 160);
			while (items_sent < quota && items_sent < ITEM_TARGET)
				random_item();
		end

		settle();
		repeat (QUERY_CYCLES_MAX)
			@(negedge clk);
		leftover_check <= 1'b1;
		repeat (2)
			@(negedge clk);
		$display("covered %0d items under %0d sphere_count settings", items_sent,
			settings_run);
		$display("%0d occlusion queries checked, %0d of them blocked", chk_queries, chk_hits);
		if (chk_fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
